>>> rtl/rigid_body_transform_unit_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rigid body transform unit.
// Each macro checks on the rising edge of clk and is quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RIGID_BODY_TRANSFORM_UNIT_CORE_DEFINES_SVH
`define RIGID_BODY_TRANSFORM_UNIT_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBTU_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBTU_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/rbtu_pkg.sv
// ----------------------------------------------------------------------------
// rbtu_pkg
// Shared constants, types and constant tables of the rigid body transform unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbtu_pkg;

  localparam int CORDIC_STEPS_DEF    = 24;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int CNT_W               = 5;

  localparam logic [1:0] OP_MOVE   = 2'd0;
  localparam logic [1:0] OP_ROTATE = 2'd1;
  localparam logic [1:0] OP_XFORM  = 2'd2;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
  localparam logic signed [31:0] DEG2RAD_Q36 = 32'sd1199381129;
  localparam longint             K_INF_Q30   = 64'sd652032874;

  typedef struct packed {
    logic             load_ang;
    logic             load_pt;
    logic             move;
    logic             red_step;
    logic             norm;
    logic             fold;
    logic             rad_mul;
    logic             rad_set;
    logic             cord_step;
    logic             clamp;
    logic             mac_step;
    logic             res_store;
    logic             commit;
    logic             out_load;
    logic             rot_mode;
    logic [1:0]       row;
    logic [1:0]       col;
    logic [1:0]       term;
    logic [CNT_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  function automatic logic signed [33:0] atan_q30(input logic [CNT_W-1:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:    v = 34'sd843314857;
      5'd1:    v = 34'sd497837829;
      5'd2:    v = 34'sd263043837;
      5'd3:    v = 34'sd133525159;
      5'd4:    v = 34'sd67021687;
      5'd5:    v = 34'sd33543516;
      5'd6:    v = 34'sd16775851;
      5'd7:    v = 34'sd8388437;
      5'd8:    v = 34'sd4194283;
      5'd9:    v = 34'sd2097149;
      default: v = (i > 5'd30) ? 34'sd0 : (34'sd1 <<< (5'd30 - i));
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] cordic_k_q30(input int steps);
    longint k;
    k = K_INF_Q30 + (((K_INF_Q30 * 2) / 3) >>> (2 * steps));
    return 32'(k);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) r = 32'sh7fffffff;
    else if (v < -37'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> rtl/rbtu_if.sv
// ----------------------------------------------------------------------------
// rbtu_in_if / rbtu_out_if
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rbtu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [1:0]         axis_sel;
  logic signed [31:0] angle;
  logic signed [31:0] val_x;
  logic signed [31:0] val_y;
  logic signed [31:0] val_z;

  modport source (output valid, opcode, axis_sel, angle, val_x, val_y, val_z,
                  input ready);
  modport sink (input valid, opcode, axis_sel, angle, val_x, val_y, val_z,
                output ready);
endinterface

interface rbtu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

>>> rtl/rbtu_ctrl.sv
// ----------------------------------------------------------------------------
// rbtu_ctrl
// Sequencer: angle reduction, CORDIC, multiply-accumulate passes and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbtu_ctrl import rbtu_pkg::*; #(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [1:0] in_opcode,
  input  logic [1:0] in_axis,
  output logic       in_rdy,
  input  stat_t      stat,
  output cmd_t       cmd
);

  localparam int RED_STEPS = (COORD_FRAC_BITS < 23) ? 24 - COORD_FRAC_BITS : 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RED    = 4'd1;
  localparam logic [3:0] S_NORM   = 4'd2;
  localparam logic [3:0] S_FOLD   = 4'd3;
  localparam logic [3:0] S_RAD    = 4'd4;
  localparam logic [3:0] S_RADW   = 4'd5;
  localparam logic [3:0] S_CORD   = 4'd6;
  localparam logic [3:0] S_CLAMP  = 4'd7;
  localparam logic [3:0] S_MAC    = 4'd8;
  localparam logic [3:0] S_RES    = 4'd9;
  localparam logic [3:0] S_COMMIT = 4'd10;
  localparam logic [3:0] S_OUTW   = 4'd11;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic             mode_r, mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      mode_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      mode_r  <= mode_nxt;
    end
  end

  assign in_rdy = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    mode_nxt  = mode_r;
    cmd       = '0;
    cmd.rot_mode = mode_r;
    cmd.row      = i_r;
    cmd.col      = j_r;
    cmd.term     = k_r;
    cmd.step     = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          i_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
          case (in_opcode)
            OP_MOVE: cmd.move = 1'b1;
            OP_ROTATE: begin
              if (in_axis != AXIS_NONE) begin
                cmd.load_ang = 1'b1;
                mode_nxt     = 1'b1;
                cnt_nxt      = CNT_W'(RED_STEPS - 1);
                state_nxt    = S_RED;
              end
            end
            OP_XFORM: begin
              cmd.load_pt = 1'b1;
              mode_nxt    = 1'b0;
              state_nxt   = S_MAC;
            end
            default: ;
          endcase
        end
      end
      S_RED: begin
        cmd.red_step = 1'b1;
        if (cnt_r == '0) state_nxt = S_NORM;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_NORM: begin
        cmd.norm  = 1'b1;
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = S_RAD;
      end
      S_RAD: begin
        cmd.rad_mul = 1'b1;
        state_nxt   = S_RADW;
      end
      S_RADW: begin
        cmd.rad_set = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_CORD;
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) state_nxt = S_CLAMP;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        if (k_r == 2'd3) begin
          k_nxt     = '0;
          state_nxt = S_RES;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_RES: begin
        cmd.res_store = 1'b1;
        if (i_r == 2'd2 && (j_r == 2'd2 || !mode_r)) begin
          state_nxt = mode_r ? S_COMMIT : S_OUTW;
        end else begin
          state_nxt = S_MAC;
          if (mode_r && j_r != 2'd2) begin
            j_nxt = j_r + 1'b1;
          end else begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
          end
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_OUTW: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> rtl/rbtu_dp.sv
// ----------------------------------------------------------------------------
// rbtu_dp
// Pose registers, angle reduction, CORDIC, shared multiplier and output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbtu_dp import rbtu_pkg::*; #(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [1:0]         in_axis,
  input  logic signed [31:0] in_angle,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  output logic               out_vld,
  input  logic               out_rdy,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);

  localparam logic [39:0]        FULL    = 40'd360 << COORD_FRAC_BITS;
  localparam logic signed [33:0] FULL_S  = 34'sd360 <<< COORD_FRAC_BITS;
  localparam logic signed [33:0] HALF_S  = 34'sd180 <<< COORD_FRAC_BITS;
  localparam logic signed [33:0] QUART_S = 34'sd90 <<< COORD_FRAC_BITS;
  localparam logic [63:0]        RAD_RND = 64'd1 << (COORD_FRAC_BITS + 5);
  localparam logic signed [31:0] CORD_K  = cordic_k_q30(CORDIC_STEPS);

  logic signed [31:0] rot_r [9];
  logic signed [31:0] nm_r [9];
  logic signed [31:0] t_r [3];
  logic signed [31:0] v_r [3];
  logic [1:0]         axis_r;
  logic [31:0]        amag_r;
  logic               neg_r, flip_r, msign_r;
  logic signed [33:0] m_r;
  logic [31:0]        mag_r;
  logic signed [63:0] p_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic signed [31:0] c_r, s_r;
  logic signed [65:0] acc_r;
  logic               out_vld_r;
  logic signed [31:0] ox_r, oy_r, oz_r;

  logic [39:0]        red_sub;
  logic signed [33:0] m_a, m_b;
  logic signed [33:0] f_m;
  logic [63:0]        rad_full;
  logic signed [33:0] dx, dy, at;
  logic [1:0]         ksel;
  logic [3:0]         ridx;
  logic signed [31:0] mul_a, mul_b, rm_e;
  logic signed [35:0] dot;
  logic signed [36:0] res_sum;
  logic [3:0]         widx;

  function automatic logic signed [31:0] rm_elem(input logic [1:0] ax, input logic [1:0] r,
                                                 input logic [1:0] q,
                                                 input logic signed [31:0] c,
                                                 input logic signed [31:0] s);
    logic signed [31:0] e;
    e = (r == q) ? ONE_Q30 : 32'sd0;
    case (ax)
      AXIS_X: begin
        if (r == 2'd1 && q == 2'd1) e = c;
        if (r == 2'd1 && q == 2'd2) e = -s;
        if (r == 2'd2 && q == 2'd1) e = s;
        if (r == 2'd2 && q == 2'd2) e = c;
      end
      AXIS_Y: begin
        if (r == 2'd0 && q == 2'd0) e = c;
        if (r == 2'd0 && q == 2'd2) e = s;
        if (r == 2'd2 && q == 2'd0) e = -s;
        if (r == 2'd2 && q == 2'd2) e = c;
      end
      AXIS_Z: begin
        if (r == 2'd0 && q == 2'd0) e = c;
        if (r == 2'd0 && q == 2'd1) e = -s;
        if (r == 2'd1 && q == 2'd0) e = s;
        if (r == 2'd1 && q == 2'd1) e = c;
      end
      default: ;
    endcase
    return e;
  endfunction

  always_comb begin
    red_sub = FULL << cmd.step;

    m_a = neg_r ? -$signed({2'b00, amag_r}) : $signed({2'b00, amag_r});
    if (m_a < 0) m_a = m_a + FULL_S;
    m_b = (m_a >= HALF_S) ? m_a - FULL_S : m_a;

    if (m_r > QUART_S) f_m = m_r - HALF_S;
    else if (m_r < -QUART_S) f_m = m_r + HALF_S;
    else f_m = m_r;

    rad_full = (64'(p_r) + RAD_RND) >> (COORD_FRAC_BITS + 6);

    dx = y_r >>> cmd.step;
    dy = x_r >>> cmd.step;
    at = atan_q30(cmd.step);

    ksel = (cmd.term == 2'd3) ? 2'd0 : cmd.term;
    ridx = cmd.rot_mode ? 4'(ksel) * 4'd3 + 4'(cmd.col) : 4'(cmd.row) * 4'd3 + 4'(ksel);
    rm_e = rm_elem(axis_r, cmd.row, ksel, c_r, s_r);
    if (cmd.rad_mul) begin
      mul_a = $signed(mag_r);
      mul_b = DEG2RAD_Q36;
    end else if (cmd.rot_mode) begin
      mul_a = rm_e;
      mul_b = rot_r[ridx];
    end else begin
      mul_a = rot_r[ridx];
      mul_b = v_r[ksel];
    end

    dot     = 36'((acc_r + 66'sd536870912) >>> 30);
    res_sum = cmd.rot_mode ? 37'(dot) : 37'(dot) + 37'(t_r[cmd.row]);
    widx    = cmd.rot_mode ? 4'(cmd.row) * 4'd3 + 4'(cmd.col) : 4'(cmd.row);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < 9; n++) rot_r[n] <= (n % 4 == 0) ? ONE_Q30 : 32'sd0;
      for (int n = 0; n < 3; n++) t_r[n] <= 32'sd0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.move) begin
        t_r[0] <= sat32(37'(t_r[0]) + 37'(in_x));
        t_r[1] <= sat32(37'(t_r[1]) + 37'(in_y));
        t_r[2] <= sat32(37'(t_r[2]) + 37'(in_z));
      end
      if (cmd.commit) begin
        for (int n = 0; n < 9; n++) rot_r[n] <= nm_r[n];
      end
      if (cmd.out_load) out_vld_r <= 1'b1;
      else if (out_rdy) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ang) begin
      axis_r <= in_axis;
      neg_r  <= in_angle[31];
      amag_r <= in_angle[31] ? 32'(-in_angle) : 32'(in_angle);
    end
    if (cmd.load_pt) begin
      v_r[0] <= in_x;
      v_r[1] <= in_y;
      v_r[2] <= in_z;
    end
    if (cmd.red_step && {8'd0, amag_r} >= red_sub) amag_r <= 32'({8'd0, amag_r} - red_sub);
    if (cmd.norm) m_r <= m_b;
    if (cmd.fold) begin
      flip_r  <= (m_r > QUART_S) || (m_r < -QUART_S);
      msign_r <= f_m[33];
      mag_r   <= f_m[33] ? 32'(-f_m) : 32'(f_m);
    end
    p_r <= mul_a * mul_b;
    if (cmd.rad_set) begin
      x_r <= 34'(CORD_K);
      y_r <= '0;
      z_r <= msign_r ? -$signed(rad_full[33:0]) : $signed(rad_full[33:0]);
    end
    if (cmd.cord_step) begin
      if (!z_r[33]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
    if (cmd.clamp) begin
      if (x_r > 34'(ONE_Q30)) c_r <= flip_r ? -ONE_Q30 : ONE_Q30;
      else if (x_r < -34'(ONE_Q30)) c_r <= flip_r ? ONE_Q30 : -ONE_Q30;
      else c_r <= flip_r ? -x_r[31:0] : x_r[31:0];
      if (y_r > 34'(ONE_Q30)) s_r <= flip_r ? -ONE_Q30 : ONE_Q30;
      else if (y_r < -34'(ONE_Q30)) s_r <= flip_r ? ONE_Q30 : -ONE_Q30;
      else s_r <= flip_r ? -y_r[31:0] : y_r[31:0];
    end
    if (cmd.mac_step) begin
      if (cmd.term == 2'd0) acc_r <= '0;
      else acc_r <= acc_r + 66'(p_r);
    end
    if (cmd.res_store) nm_r[widx] <= sat32(res_sum);
    if (cmd.out_load) begin
      ox_r <= nm_r[0];
      oy_r <= nm_r[1];
      oz_r <= nm_r[2];
    end
  end

  assign stat.out_busy = out_vld_r && !out_rdy;
  assign out_vld       = out_vld_r;
  assign out_x         = ox_r;
  assign out_y         = oy_r;
  assign out_z         = oz_r;

endmodule

>>> rtl/rigid_body_transform_unit_core.sv
// ----------------------------------------------------------------------------
// rigid_body_transform_unit_core
// Keeps a rigid body pose and moves, rotates or applies it per input beat.
// ----------------------------------------------------------------------------
// Input beats arrive on in_bus with an opcode: move adds a delta to the
// translation, rotate premultiplies the rotation block by an elementary
// rotation about x, y or z, and transform sends one point through the pose.
// Only transform produces a result beat, on out_bus.
// A move is applied on acceptance and the next beat can follow directly. A
// transform sends three rows of three products through one shared 32x32
// multiplier before its result reaches the result register. A rotate runs
// (24 - COORD_FRAC_BITS, but at least one) reduction steps, folds and scales
// the angle, runs CORDIC_STEPS CORDIC steps, clamps, computes the nine matrix
// entries and commits before the next beat is accepted.
// A result waits in the output register while a new beat is taken; a second
// transform only finishes once that register has been read.
// Reset (synchronous, rst_n low) restores the identity rotation and a zero
// translation and drops any pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rigid_body_transform_unit_core_defines.svh"

module rigid_body_transform_unit_core import rbtu_pkg::*; #(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  rbtu_in_if.sink     in_bus,
  rbtu_out_if.source  out_bus
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_fire;
  logic  in_rdy;
  logic  rot_fire;
  logic  move_fire;

  assign in_bus.ready = in_rdy;
  assign in_fire      = in_bus.valid && in_rdy;
  assign rot_fire     = in_fire && in_bus.opcode == OP_ROTATE && in_bus.axis_sel != AXIS_NONE;
  assign move_fire    = in_fire && in_bus.opcode == OP_MOVE;

  rbtu_ctrl #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_opcode (in_bus.opcode),
    .in_axis   (in_bus.axis_sel),
    .in_rdy    (in_rdy),
    .stat      (stat),
    .cmd       (cmd)
  );

  rbtu_dp #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_axis  (in_bus.axis_sel),
    .in_angle (in_bus.angle),
    .in_x     (in_bus.val_x),
    .in_y     (in_bus.val_y),
    .in_z     (in_bus.val_z),
    .out_vld  (out_bus.valid),
    .out_rdy  (out_bus.ready),
    .out_x    (out_bus.out_x),
    .out_y    (out_bus.out_y),
    .out_z    (out_bus.out_z)
  );

  `RBTU_ASSERT_NEXT(a_rot_busy, rot_fire, !in_bus.ready, "rotate beat did not start the sequencer")
  `RBTU_ASSERT_NEXT(a_move_idle, move_fire, in_bus.ready, "move beat left the unit busy")
  `RBTU_ASSERT_NOW(a_cmd_excl, 1'b1, $onehot0({cmd.red_step, cmd.cord_step, cmd.res_store, cmd.commit, cmd.out_load}), "conflicting datapath commands")

endmodule
